>>> sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define RTI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ray triangle assertion failed");

// same-cycle implication
`define RTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `RTI_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// next-cycle implication
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `RTI_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> sv/rti_pkg.sv
// shared widths, types and helpers of the ray/triangle intersection block
// no dependencies
package rti_pkg;

    localparam int COORD_BITS = 20;
    localparam int FW    = 60;              // packed vector field
    localparam int CW    = COORD_BITS;
    localparam int EXTW  = 3 * CW;
    localparam int DW    = CW + 1;          // edge and offset vectors
    localparam int MW    = 2 * DW;          // cross product terms
    localparam int SW    = MW + 1;          // cross product results
    localparam int PW    = SW + DW;         // dot product terms
    localparam int NW    = PW + 2;          // determinant and numerators
    localparam int FRAC  = 16;
    localparam int LW    = NW + FRAC;       // scaled t numerator
    localparam int SPLIT = 33;              // determinant split for range multiply
    localparam int LPW   = SPLIT + 1 + 32;
    localparam int HPW   = NW - SPLIT + 1 + 32;
    localparam int CMPW  = NW + 33;
    localparam int TQ    = 32;              // quotient bits of t
    localparam int BQ    = 17;              // quotient bits of b1, b2
    localparam int RW    = NW + TQ;         // divider remainder

    localparam logic [31:0] T_POS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] T_NEG_MIN = 32'h8000_0000;
    localparam logic [16:0] BARY_ONE  = 17'd65536;

    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    typedef logic [FW-1:0] packed_t;
    typedef logic [2:0][CW-1:0] cvec_t;
    typedef logic [2:0][DW-1:0] dvec_t;
    typedef logic [5:0][MW-1:0] prod6_t;
    typedef logic [2:0][SW-1:0] svec_t;
    typedef logic [2:0][PW-1:0] term3_t;

    typedef enum logic [2:0] {
        CAUSE_HIT,
        CAUSE_PARALLEL,
        CAUSE_B1_OUT,
        CAUSE_B2_OUT,
        CAUSE_T_OUT
    } cause_t;

    typedef struct packed {
        logic signed [NW-1:0] det;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
        logic signed [NW-1:0] nt;
        logic signed [31:0]   tmin;
        logic signed [31:0]   tmax;
    } geom_res_t;

    typedef struct packed {
        cause_t               cause;
        logic signed [NW-1:0] det;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
        logic signed [LW-1:0] lhs;
    } test_res_t;

    // split a packed field into x, y, z; bits above the field read as zero
    function automatic cvec_t unpack_vec(input packed_t p);
        logic [EXTW-1:0] ext;
        cvec_t v;
        ext = EXTW'(p);
        for (int k = 0; k < 3; k++)
        begin
            v[k] = ext[k*CW +: CW];
        end
        return v;
    endfunction

endpackage

>>> sv/rti_if.sv
// item channels of the ray/triangle intersection block
// depends on rti_pkg
interface rti_in_if import rti_pkg::*; ();
    logic               valid;
    logic               ready;
    packed_t            ray_origin;
    packed_t            ray_direction;
    packed_t            vertex_a;
    packed_t            vertex_b;
    packed_t            vertex_c;
    logic signed [31:0] t_min;
    logic signed [31:0] t_max;

    modport source (output valid, ray_origin, ray_direction, vertex_a, vertex_b,
                    vertex_c, t_min, t_max, input ready);
    modport sink   (input valid, ray_origin, ray_direction, vertex_a, vertex_b,
                    vertex_c, t_min, t_max, output ready);
endinterface

interface rti_out_if import rti_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [2:0]         miss_cause;
    logic signed [31:0] distance;
    logic [16:0]        bary_one;
    logic [16:0]        bary_two;

    modport source (output valid, hit, miss_cause, distance, bary_one, bary_two,
                    input ready);
    modport sink   (input valid, hit, miss_cause, distance, bary_one, bary_two,
                    output ready);
endinterface

>>> sv/rti_geom.sv
// geometry pipeline: edges, cross products, determinant and numerators
// depends on rti_pkg
module rti_geom import rti_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  packed_t            ray_origin,
    input  packed_t            ray_direction,
    input  packed_t            vertex_a,
    input  packed_t            vertex_b,
    input  packed_t            vertex_c,
    input  logic signed [31:0] t_min,
    input  logic signed [31:0] t_max,
    output logic               out_valid,
    input  logic               out_ready,
    output geom_res_t          out_item
);

    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic           en;
    logic           hold_full_reg, hold_full_next;
    geom_res_t      hold_reg;

    logic signed [31:0] tmin_reg [NST-1];
    logic signed [31:0] tmax_reg [NST-1];

    cvec_t o0_reg, dir0_reg, a0_reg, b0_reg, c0_reg;
    cvec_t dir1_reg, dir2_reg, dir3_reg;
    dvec_t e1_1_reg, e2_1_reg, dv1_reg, e1_1_next, e2_1_next, dv1_next;
    dvec_t e1_2_reg, e2_2_reg, dv2_reg;
    dvec_t e1_3_reg, e2_3_reg, dv3_reg;
    prod6_t p1_reg, p2_reg, p1_next, p2_next;
    svec_t  s1_reg, s2_reg, s1_next, s2_next;
    term3_t td_reg, tn1_reg, tn2_reg, tnt_reg, td_next, tn1_next, tn2_next, tnt_next;
    geom_res_t res_reg, res_next;

    // whole pipeline moves unless the skid slot is occupied
    assign en       = !hold_full_reg;
    assign in_ready = en;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            hold_full_reg <= 1'b0;
        end
        else
        begin
            hold_full_reg <= hold_full_next;
            if (en)
            begin
                v_reg <= {v_reg[NST-2:0], in_valid};
            end
        end
    end

    // skid slot catches the output item when the pipeline shifts under a stall
    always_comb
    begin
        hold_full_next = hold_full_reg;
        if (hold_full_reg)
        begin
            hold_full_next = !out_ready;
        end
        else if (v_reg[NST-1] && !out_ready)
        begin
            hold_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_full_reg && v_reg[NST-1] && !out_ready)
        begin
            hold_reg <= res_reg;
        end
    end

    assign out_valid = hold_full_reg || v_reg[NST-1];
    assign out_item  = hold_full_reg ? hold_reg : res_reg;

    // edge and offset vectors
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_1_next[k] = DW'($signed(b0_reg[k])) - DW'($signed(a0_reg[k]));
            e2_1_next[k] = DW'($signed(c0_reg[k])) - DW'($signed(a0_reg[k]));
            dv1_next[k]  = DW'($signed(o0_reg[k])) - DW'($signed(a0_reg[k]));
        end
    end

    // cross product terms: s1 = dir x e2, s2 = dv x e1
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p1_next[2*k]   = $signed(dir1_reg[NXT1[k]]) * $signed(e2_1_reg[NXT2[k]]);
            p1_next[2*k+1] = $signed(dir1_reg[NXT2[k]]) * $signed(e2_1_reg[NXT1[k]]);
            p2_next[2*k]   = $signed(dv1_reg[NXT1[k]]) * $signed(e1_1_reg[NXT2[k]]);
            p2_next[2*k+1] = $signed(dv1_reg[NXT2[k]]) * $signed(e1_1_reg[NXT1[k]]);
        end
    end

    // cross product differences
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_next[k] = SW'($signed(p1_reg[2*k])) - SW'($signed(p1_reg[2*k+1]));
            s2_next[k] = SW'($signed(p2_reg[2*k])) - SW'($signed(p2_reg[2*k+1]));
        end
    end

    // dot product terms
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            td_next[k]  = $signed(s1_reg[k]) * $signed(e1_3_reg[k]);
            tn1_next[k] = $signed(dv3_reg[k]) * $signed(s1_reg[k]);
            tn2_next[k] = $signed(dir3_reg[k]) * $signed(s2_reg[k]);
            tnt_next[k] = $signed(e2_3_reg[k]) * $signed(s2_reg[k]);
        end
    end

    // dot product sums
    always_comb
    begin
        res_next.det  = NW'($signed(td_reg[0])) + NW'($signed(td_reg[1]))
                      + NW'($signed(td_reg[2]));
        res_next.n1   = NW'($signed(tn1_reg[0])) + NW'($signed(tn1_reg[1]))
                      + NW'($signed(tn1_reg[2]));
        res_next.n2   = NW'($signed(tn2_reg[0])) + NW'($signed(tn2_reg[1]))
                      + NW'($signed(tn2_reg[2]));
        res_next.nt   = NW'($signed(tnt_reg[0])) + NW'($signed(tnt_reg[1]))
                      + NW'($signed(tnt_reg[2]));
        res_next.tmin = tmin_reg[NST-2];
        res_next.tmax = tmax_reg[NST-2];
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o0_reg   <= unpack_vec(ray_origin);
            dir0_reg <= unpack_vec(ray_direction);
            a0_reg   <= unpack_vec(vertex_a);
            b0_reg   <= unpack_vec(vertex_b);
            c0_reg   <= unpack_vec(vertex_c);
            tmin_reg[0] <= t_min;
            tmax_reg[0] <= t_max;
            for (int s = 1; s < NST - 1; s++)
            begin
                tmin_reg[s] <= tmin_reg[s-1];
                tmax_reg[s] <= tmax_reg[s-1];
            end

            dir1_reg <= dir0_reg;
            e1_1_reg <= e1_1_next;
            e2_1_reg <= e2_1_next;
            dv1_reg  <= dv1_next;

            dir2_reg <= dir1_reg;
            e1_2_reg <= e1_1_reg;
            e2_2_reg <= e2_1_reg;
            dv2_reg  <= dv1_reg;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;

            dir3_reg <= dir2_reg;
            e1_3_reg <= e1_2_reg;
            e2_3_reg <= e2_2_reg;
            dv3_reg  <= dv2_reg;
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;

            td_reg  <= td_next;
            tn1_reg <= tn1_next;
            tn2_reg <= tn2_next;
            tnt_reg <= tnt_next;

            res_reg <= res_next;
        end
    end

endmodule

>>> sv/rti_test.sv
// sign correction and range tests that pick the miss cause
// depends on rti_pkg
module rti_test import rti_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  geom_res_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output test_res_t out_item
);

    localparam int NST = 3;

    logic [NST-1:0] v_reg;
    logic           en;
    logic           hold_full_reg, hold_full_next;
    test_res_t      hold_reg;

    logic signed [NW-1:0] det0_next, n10_next, n20_next, nt0_next;
    logic signed [NW-1:0] det0_reg, n10_reg, n20_reg, det1_reg, n11_reg, n21_reg;
    logic signed [LW-1:0] lhs0_reg, lhs1_reg;
    logic signed [31:0]   tmin0_reg, tmax0_reg;
    logic                 zero0_reg, zero1_reg;
    logic                 c2_next, c3_next, c2_reg, c3_reg;
    logic signed [LPW-1:0] plo_min_next, plo_max_next, plo_min_reg, plo_max_reg;
    logic signed [HPW-1:0] phi_min_next, phi_max_next, phi_min_reg, phi_max_reg;
    logic signed [CMPW-1:0] lim_min, lim_max, lhs_ext;
    test_res_t res_reg, res_next;

    assign en       = !hold_full_reg;
    assign in_ready = en;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            hold_full_reg <= 1'b0;
        end
        else
        begin
            hold_full_reg <= hold_full_next;
            if (en)
            begin
                v_reg <= {v_reg[NST-2:0], in_valid};
            end
        end
    end

    // skid slot
    always_comb
    begin
        hold_full_next = hold_full_reg;
        if (hold_full_reg)
        begin
            hold_full_next = !out_ready;
        end
        else if (v_reg[NST-1] && !out_ready)
        begin
            hold_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_full_reg && v_reg[NST-1] && !out_ready)
        begin
            hold_reg <= res_reg;
        end
    end

    assign out_valid = hold_full_reg || v_reg[NST-1];
    assign out_item  = hold_full_reg ? hold_reg : res_reg;

    // make the determinant nonnegative
    always_comb
    begin
        if (in_item.det[NW-1])
        begin
            det0_next = -in_item.det;
            n10_next  = -in_item.n1;
            n20_next  = -in_item.n2;
            nt0_next  = -in_item.nt;
        end
        else
        begin
            det0_next = in_item.det;
            n10_next  = in_item.n1;
            n20_next  = in_item.n2;
            nt0_next  = in_item.nt;
        end
    end

    // barycentric checks and partial products of det * t limits
    always_comb
    begin
        c2_next = n10_reg[NW-1] || (det0_reg < n10_reg);
        c3_next = n20_reg[NW-1]
               || ((NW+1)'(det0_reg) < ((NW+1)'(n10_reg) + (NW+1)'(n20_reg)));
        plo_min_next = $signed({1'b0, det0_reg[SPLIT-1:0]}) * tmin0_reg;
        plo_max_next = $signed({1'b0, det0_reg[SPLIT-1:0]}) * tmax0_reg;
        phi_min_next = $signed({1'b0, det0_reg[NW-1:SPLIT]}) * tmin0_reg;
        phi_max_next = $signed({1'b0, det0_reg[NW-1:SPLIT]}) * tmax0_reg;
    end

    // distance window check and cause selection in check order
    always_comb
    begin
        lim_min = (CMPW'(phi_min_reg) <<< SPLIT) + CMPW'(plo_min_reg);
        lim_max = (CMPW'(phi_max_reg) <<< SPLIT) + CMPW'(plo_max_reg);
        lhs_ext = CMPW'(lhs1_reg);
        if (zero1_reg)
        begin
            res_next.cause = CAUSE_PARALLEL;
        end
        else if (c2_reg)
        begin
            res_next.cause = CAUSE_B1_OUT;
        end
        else if (c3_reg)
        begin
            res_next.cause = CAUSE_B2_OUT;
        end
        else if ((lhs_ext < lim_min) || (lim_max < lhs_ext))
        begin
            res_next.cause = CAUSE_T_OUT;
        end
        else
        begin
            res_next.cause = CAUSE_HIT;
        end
        res_next.det = det1_reg;
        res_next.n1  = n11_reg;
        res_next.n2  = n21_reg;
        res_next.lhs = lhs1_reg;
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det0_reg  <= det0_next;
            n10_reg   <= n10_next;
            n20_reg   <= n20_next;
            lhs0_reg  <= {nt0_next, {FRAC{1'b0}}};
            zero0_reg <= (in_item.det == '0);
            tmin0_reg <= in_item.tmin;
            tmax0_reg <= in_item.tmax;

            det1_reg    <= det0_reg;
            n11_reg     <= n10_reg;
            n21_reg     <= n20_reg;
            lhs1_reg    <= lhs0_reg;
            zero1_reg   <= zero0_reg;
            c2_reg      <= c2_next;
            c3_reg      <= c3_next;
            plo_min_reg <= plo_min_next;
            plo_max_reg <= plo_max_next;
            phi_min_reg <= phi_min_next;
            phi_max_reg <= phi_max_next;

            res_reg <= res_next;
        end
    end

endmodule

>>> sv/rti_div.sv
// pipelined restoring dividers for t, b1, b2 and result formatting
// depends on rti_pkg
module rti_div import rti_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  test_res_t          in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [2:0]         miss_cause,
    output logic signed [31:0] distance,
    output logic [16:0]        bary_one,
    output logic [16:0]        bary_two
);

    // stage 0 loads, stages 1..TQ each resolve one quotient bit, then output
    localparam int NS  = TQ + 1;
    localparam int NST = NS + 1;

    logic [NST-1:0] v_reg;
    logic           en;
    logic           hold_full_reg, hold_full_next;

    logic [RW-1:0] rt_reg [NS];
    logic [RW-1:0] r1_reg [NS];
    logic [RW-1:0] r2_reg [NS];
    logic [RW-1:0] rt_next [NS];
    logic [RW-1:0] r1_next [NS];
    logic [RW-1:0] r2_next [NS];
    logic [TQ-1:0] qt_reg [NS];
    logic [TQ-1:0] qt_next [NS];
    logic [BQ-1:0] q1_reg [NS];
    logic [BQ-1:0] q2_reg [NS];
    logic [BQ-1:0] q1_next [NS];
    logic [BQ-1:0] q2_next [NS];
    logic [NW-1:0] det_reg [NS];
    logic          neg_reg [NS];
    cause_t        cause_reg [NS];

    logic [LW-1:0] mag;

    logic               hit_reg, hit_next, hold_hit_reg;
    logic [2:0]         mc_reg, mc_next, hold_mc_reg;
    logic signed [31:0] dist_reg, dist_next, hold_dist_reg;
    logic [16:0]        b1_reg, b1_next, hold_b1_reg;
    logic [16:0]        b2_reg, b2_next, hold_b2_reg;

    assign en       = !hold_full_reg;
    assign in_ready = en;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            hold_full_reg <= 1'b0;
        end
        else
        begin
            hold_full_reg <= hold_full_next;
            if (en)
            begin
                v_reg <= {v_reg[NST-2:0], in_valid};
            end
        end
    end

    // skid slot
    always_comb
    begin
        hold_full_next = hold_full_reg;
        if (hold_full_reg)
        begin
            hold_full_next = !out_ready;
        end
        else if (v_reg[NST-1] && !out_ready)
        begin
            hold_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_full_reg && v_reg[NST-1] && !out_ready)
        begin
            hold_hit_reg  <= hit_reg;
            hold_mc_reg   <= mc_reg;
            hold_dist_reg <= dist_reg;
            hold_b1_reg   <= b1_reg;
            hold_b2_reg   <= b2_reg;
        end
    end

    assign out_valid  = hold_full_reg || v_reg[NST-1];
    assign hit        = hold_full_reg ? hold_hit_reg  : hit_reg;
    assign miss_cause = hold_full_reg ? hold_mc_reg   : mc_reg;
    assign distance   = hold_full_reg ? hold_dist_reg : dist_reg;
    assign bary_one   = hold_full_reg ? hold_b1_reg   : b1_reg;
    assign bary_two   = hold_full_reg ? hold_b2_reg   : b2_reg;

    // load the magnitude of the scaled t numerator and the scaled b numerators,
    // then one quotient bit per stage, t from its top bit down, b1 and b2 alongside
    always_comb
    begin
        mag = in_item.lhs[LW-1] ? LW'(-in_item.lhs) : LW'(in_item.lhs);
        rt_next[0] = RW'(mag);
        r1_next[0] = RW'({in_item.n1, {FRAC{1'b0}}});
        r2_next[0] = RW'({in_item.n2, {FRAC{1'b0}}});
        qt_next[0] = '0;
        q1_next[0] = '0;
        q2_next[0] = '0;
        for (int s = 1; s < NS; s++)
        begin
            logic [RW-1:0] dsh_t;
            logic [RW-1:0] dsh_b;
            dsh_t = RW'(det_reg[s-1]) << (TQ - s);
            dsh_b = '0;
            rt_next[s] = rt_reg[s-1];
            qt_next[s] = qt_reg[s-1];
            r1_next[s] = r1_reg[s-1];
            r2_next[s] = r2_reg[s-1];
            q1_next[s] = q1_reg[s-1];
            q2_next[s] = q2_reg[s-1];
            if (rt_reg[s-1] >= dsh_t)
            begin
                rt_next[s] = rt_reg[s-1] - dsh_t;
                qt_next[s][TQ-s] = 1'b1;
            end
            if (s <= BQ)
            begin
                dsh_b = RW'(det_reg[s-1]) << (BQ - s);
                if (r1_reg[s-1] >= dsh_b)
                begin
                    r1_next[s] = r1_reg[s-1] - dsh_b;
                    q1_next[s][BQ-s] = 1'b1;
                end
                if (r2_reg[s-1] >= dsh_b)
                begin
                    r2_next[s] = r2_reg[s-1] - dsh_b;
                    q2_next[s][BQ-s] = 1'b1;
                end
            end
        end
    end

    // saturate, sign and zero the fields of a miss
    always_comb
    begin
        hit_next  = (cause_reg[NS-1] == CAUSE_HIT);
        mc_next   = cause_reg[NS-1];
        dist_next = '0;
        b1_next   = '0;
        b2_next   = '0;
        if (hit_next)
        begin
            if (!neg_reg[NS-1])
            begin
                dist_next = (qt_reg[NS-1] > T_POS_MAX) ? T_POS_MAX : qt_reg[NS-1];
            end
            else
            begin
                dist_next = (qt_reg[NS-1] > T_NEG_MIN) ? T_NEG_MIN : (32'd0 - qt_reg[NS-1]);
            end
            b1_next = (q1_reg[NS-1] > BARY_ONE) ? BARY_ONE : q1_reg[NS-1];
            b2_next = (q2_reg[NS-1] > BARY_ONE) ? BARY_ONE : q2_reg[NS-1];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg[0]   <= NW'(in_item.det);
            neg_reg[0]   <= in_item.lhs[LW-1];
            cause_reg[0] <= in_item.cause;
            for (int s = 1; s < NS; s++)
            begin
                det_reg[s]   <= det_reg[s-1];
                neg_reg[s]   <= neg_reg[s-1];
                cause_reg[s] <= cause_reg[s-1];
            end
            for (int s = 0; s < NS; s++)
            begin
                rt_reg[s] <= rt_next[s];
                r1_reg[s] <= r1_next[s];
                r2_reg[s] <= r2_next[s];
                qt_reg[s] <= qt_next[s];
                q1_reg[s] <= q1_next[s];
                q2_reg[s] <= q2_next[s];
            end
            hit_reg  <= hit_next;
            mc_reg   <= mc_next;
            dist_reg <= dist_next;
            b1_reg   <= b1_next;
            b2_reg   <= b2_next;
        end
    end

endmodule

>>> sv/ray_triangle_intersect.sv
// top level of the fixed-point ray/triangle intersection unit
// depends on rti_pkg, rti_if, rti_geom, rti_test, rti_div
//
//   channel  dir  handshake      payload
//   query    in   valid/ready    ray_origin, ray_direction, vertex_a/b/c, t_min, t_max
//   answer   out  valid/ready    hit, miss_cause, distance, bary_one, bary_two
//
// one item per cycle while the answer side accepts; 6 geometry stages,
// 3 test stages, 34 divider stages (one quotient bit of t per stage)
// rst_n clears only valid bits and skid flags; no state spans items
// each of the three sections ends in a skid slot, so a stalled answer
// still lets one more item move up; ready is registered on every side
module ray_triangle_intersect import rti_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    rti_in_if.sink   query,
    rti_out_if.source answer
);

    logic      g_valid, g_ready;
    geom_res_t g_item;
    logic      t_valid, t_ready;
    test_res_t t_item;

    // edges, cross and dot products
    rti_geom u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (query.valid),
        .in_ready      (query.ready),
        .ray_origin    (query.ray_origin),
        .ray_direction (query.ray_direction),
        .vertex_a      (query.vertex_a),
        .vertex_b      (query.vertex_b),
        .vertex_c      (query.vertex_c),
        .t_min         (query.t_min),
        .t_max         (query.t_max),
        .out_valid     (g_valid),
        .out_ready     (g_ready),
        .out_item      (g_item)
    );

    // sign correction and range checks
    rti_test u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_ready  (g_ready),
        .in_item   (g_item),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_item  (t_item)
    );

    // quotients and output formatting
    rti_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (t_valid),
        .in_ready   (t_ready),
        .in_item    (t_item),
        .out_valid  (answer.valid),
        .out_ready  (answer.ready),
        .hit        (answer.hit),
        .miss_cause (answer.miss_cause),
        .distance   (answer.distance),
        .bary_one   (answer.bary_one),
        .bary_two   (answer.bary_two)
    );

endmodule

>>> sv/rti_checker.sv
// port-level checks on the answer channel of ray_triangle_intersect
// depends on rti_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module rti_checker import rti_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [2:0]  miss_cause,
    input logic [31:0] distance,
    input logic [16:0] bary_one,
    input logic [16:0] bary_two
);

    // hit flag agrees with the cause code
    `RTI_ASSERT_IMP(a_hit_code, clk, rst_n, out_valid, hit == (miss_cause == CAUSE_HIT))

    // a miss carries zero distance and barycentrics
    `RTI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !hit, (distance == '0) && (bary_one == '0) && (bary_two == '0))

    // barycentrics of a hit stay inside the triangle
    `RTI_ASSERT_IMP(a_bary_sum, clk, rst_n, out_valid && hit, ({1'b0, bary_one} + {1'b0, bary_two}) <= {1'b0, BARY_ONE})

    // a stalled item holds
    `RTI_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(miss_cause) && $stable(distance) && $stable(bary_one) && $stable(bary_two))

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (answer.valid),
    .out_ready  (answer.ready),
    .hit        (answer.hit),
    .miss_cause (answer.miss_cause),
    .distance   (answer.distance),
    .bary_one   (answer.bary_one),
    .bary_two   (answer.bary_two)
);
